// File: rtl/ttg_pkg.sv
// Shared constants and types for the triangle tangent generator.
package ttg_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 32;
   localparam int TEXCOORD_WIDTH_DEFAULT = 16;
   localparam int TANGENT_WIDTH = 16;
   localparam int NORM_BITS = 30;
   localparam int SCALE_SHIFT = 14;
   localparam int QUOT_BITS = SCALE_SHIFT + 1;
   localparam logic [QUOT_BITS-1:0] OUT_SCALE = QUOT_BITS'(1) << SCALE_SHIFT;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DET,
      BK_MUL,
      BK_NORM,
      BK_SQ,
      BK_SQRT,
      BK_DIV_LOAD,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// File: rtl/triangle_tangent_generator_core.sv
// Top level of the triangle tangent generator: front end, record queue and back end.
//
// Channel   Direction  Handshake        Ports
// request   in         req_push/full    req_pos_x/y/z, req_tex_u/v
// response  out        rsp_pop/empty    rsp_tangent_x/y/z, rsp_degenerate
//
// A corner is taken while req_full is low; every third one queues a triangle record.
// The back end finishes early on a zero determinant or a zero tangent; otherwise it
// runs the bit-serial normalising shifter, the square root and three divisions.
// Reset clears the held corner count, the record queue and the response register.
// A two-entry record queue and a response register let either side stall on its own.
module triangle_tangent_generator_core #(
   parameter int POSITION_WIDTH = ttg_pkg::POSITION_WIDTH_DEFAULT,
   parameter int TEXCOORD_WIDTH = ttg_pkg::TEXCOORD_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic signed [POSITION_WIDTH-1:0]         req_pos_x,
   input  logic signed [POSITION_WIDTH-1:0]         req_pos_y,
   input  logic signed [POSITION_WIDTH-1:0]         req_pos_z,
   input  logic signed [TEXCOORD_WIDTH-1:0]         req_tex_u,
   input  logic signed [TEXCOORD_WIDTH-1:0]         req_tex_v,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic signed [ttg_pkg::TANGENT_WIDTH-1:0] rsp_tangent_x,
   output logic signed [ttg_pkg::TANGENT_WIDTH-1:0] rsp_tangent_y,
   output logic signed [ttg_pkg::TANGENT_WIDTH-1:0] rsp_tangent_z,
   output logic                                     rsp_degenerate
);
   import ttg_pkg::*;

   localparam int RW = 6 * (POSITION_WIDTH + 1) + 4 * (TEXCOORD_WIDTH + 1);

   logic q_push, q_full, q_pop, q_empty;
   logic [RW-1:0] q_in_data, q_out_data;

   ttg_front #(
      .POSITION_WIDTH(POSITION_WIDTH),
      .TEXCOORD_WIDTH(TEXCOORD_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_tex_u(req_tex_u),
      .req_tex_v(req_tex_v),
      .q_push(q_push),
      .q_full(q_full),
      .q_data(q_in_data)
   );

   ttg_queue #(
      .WIDTH(RW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .full(q_full),
      .push_data(q_in_data),
      .pop(q_pop),
      .empty(q_empty),
      .pop_data(q_out_data)
   );

   ttg_back #(
      .POSITION_WIDTH(POSITION_WIDTH),
      .TEXCOORD_WIDTH(TEXCOORD_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_pop(q_pop),
      .q_data(q_out_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_tangent_x(rsp_tangent_x),
      .rsp_tangent_y(rsp_tangent_y),
      .rsp_tangent_z(rsp_tangent_z),
      .rsp_degenerate(rsp_degenerate)
   );

endmodule

// File: rtl/ttg_front.sv
// Front end: holds the first two corners and forms edges and UV deltas on the third.
module ttg_front #(
   parameter int POSITION_WIDTH = ttg_pkg::POSITION_WIDTH_DEFAULT,
   parameter int TEXCOORD_WIDTH = ttg_pkg::TEXCOORD_WIDTH_DEFAULT,
   localparam int EW = POSITION_WIDTH + 1,
   localparam int DW = TEXCOORD_WIDTH + 1,
   localparam int RW = 6 * EW + 4 * DW
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_x,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_y,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_z,
   input  logic signed [TEXCOORD_WIDTH-1:0] req_tex_u,
   input  logic signed [TEXCOORD_WIDTH-1:0] req_tex_v,
   output logic                             q_push,
   input  logic                             q_full,
   output logic [RW-1:0]                    q_data
);
   import ttg_pkg::*;

   logic [1:0] count_ff, count_in;
   logic [POSITION_WIDTH-1:0] hp_ff [2][3];
   logic [TEXCOORD_WIDTH-1:0] ht_ff [2][2];
   logic [POSITION_WIDTH-1:0] p2 [3];
   logic [EW-1:0] e1 [3];
   logic [EW-1:0] e2 [3];
   logic [DW-1:0] du1, dv1, du2, dv2;
   logic accept;

   assign p2[0] = req_pos_x;
   assign p2[1] = req_pos_y;
   assign p2[2] = req_pos_z;

   assign req_full = (count_ff == 2'd2) && q_full;
   assign accept = req_push && !req_full;
   assign q_push = accept && (count_ff == 2'd2);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = {hp_ff[1][i][POSITION_WIDTH-1], hp_ff[1][i]}
               - {hp_ff[0][i][POSITION_WIDTH-1], hp_ff[0][i]};
         e2[i] = {p2[i][POSITION_WIDTH-1], p2[i]}
               - {hp_ff[0][i][POSITION_WIDTH-1], hp_ff[0][i]};
      end
      du1 = {ht_ff[1][0][TEXCOORD_WIDTH-1], ht_ff[1][0]}
          - {ht_ff[0][0][TEXCOORD_WIDTH-1], ht_ff[0][0]};
      dv1 = {ht_ff[1][1][TEXCOORD_WIDTH-1], ht_ff[1][1]}
          - {ht_ff[0][1][TEXCOORD_WIDTH-1], ht_ff[0][1]};
      du2 = {req_tex_u[TEXCOORD_WIDTH-1], req_tex_u}
          - {ht_ff[0][0][TEXCOORD_WIDTH-1], ht_ff[0][0]};
      dv2 = {req_tex_v[TEXCOORD_WIDTH-1], req_tex_v}
          - {ht_ff[0][1][TEXCOORD_WIDTH-1], ht_ff[0][1]};
      q_data = {dv2, du2, dv1, du1, e2[2], e2[1], e2[0], e1[2], e1[1], e1[0]};
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = (count_ff == 2'd2) ? 2'd0 : count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (count_ff != 2'd2)) begin
         hp_ff[count_ff[0]][0] <= req_pos_x;
         hp_ff[count_ff[0]][1] <= req_pos_y;
         hp_ff[count_ff[0]][2] <= req_pos_z;
         ht_ff[count_ff[0]][0] <= req_tex_u;
         ht_ff[count_ff[0]][1] <= req_tex_v;
      end
   end

endmodule

// File: rtl/ttg_queue.sv
// Two-entry queue of triangle records between the front and back ends.
module ttg_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   import ttg_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ttg_back.sv
// Back end: determinant, tangent, normalisation, square root and division sequencer.
module ttg_back #(
   parameter int POSITION_WIDTH = ttg_pkg::POSITION_WIDTH_DEFAULT,
   parameter int TEXCOORD_WIDTH = ttg_pkg::TEXCOORD_WIDTH_DEFAULT,
   localparam int EW = POSITION_WIDTH + 1,
   localparam int DW = TEXCOORD_WIDTH + 1,
   localparam int RW = 6 * EW + 4 * DW
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       q_empty,
   output logic                                       q_pop,
   input  logic [RW-1:0]                              q_data,
   output logic                                       rsp_empty,
   input  logic                                       rsp_pop,
   output logic signed [ttg_pkg::TANGENT_WIDTH-1:0]   rsp_tangent_x,
   output logic signed [ttg_pkg::TANGENT_WIDTH-1:0]   rsp_tangent_y,
   output logic signed [ttg_pkg::TANGENT_WIDTH-1:0]   rsp_tangent_z,
   output logic                                       rsp_degenerate
);
   import ttg_pkg::*;

   localparam int DETW = 2 * DW + 1;
   localparam int TMW = EW + DW + 1;
   localparam int SUMW = 2 * NORM_BITS + 2;
   localparam int NUMW = NORM_BITS + SCALE_SHIFT + 1;
   localparam int LENW = NORM_BITS + 1;

   back_state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [RW-1:0] rec_ff, rec_in;
   logic det_neg_ff, det_neg_in;
   logic deg_ff, deg_in;
   logic [TMW-1:0] mag_ff [3];
   logic [TMW-1:0] mag_in [3];
   logic neg_ff [3];
   logic neg_in [3];
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [SUMW-1:0] rad_ff, rad_in;
   logic [SUMW-1:0] res_ff, res_in;
   logic [SUMW-1:0] bit_ff, bit_in;
   logic [LENW-1:0] len_ff, len_in;
   logic [NUMW-1:0] num_ff, num_in;
   logic [NUMW-1:0] dsr_ff, dsr_in;
   logic [QUOT_BITS-1:0] quo_ff, quo_in;
   logic [TANGENT_WIDTH-1:0] tan_ff [3];
   logic [TANGENT_WIDTH-1:0] tan_in [3];
   logic out_valid_ff, out_valid_in;
   logic [TANGENT_WIDTH-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic out_deg_ff, out_deg_in;

   logic signed [DETW-1:0] du1_s, dv1_s, du2_s, dv2_s, det;
   logic signed [TMW-1:0] e1_s, e2_s, dv1_t, dv2_t, tval;
   logic [TMW-1:0] or_mag;
   logic [NORM_BITS-1:0] sm;
   logic [2*NORM_BITS-1:0] sq;
   logic [SUMW-1:0] trial;
   logic [QUOT_BITS-1:0] quo_next;
   logic ge;
   logic out_free;

   assign rsp_empty = !out_valid_ff;
   assign rsp_tangent_x = out_x_ff;
   assign rsp_tangent_y = out_y_ff;
   assign rsp_tangent_z = out_z_ff;
   assign rsp_degenerate = out_deg_ff;
   assign out_free = !out_valid_ff || rsp_pop;

   always_comb begin
      du1_s = DETW'($signed(rec_ff[6*EW +: DW]));
      dv1_s = DETW'($signed(rec_ff[6*EW + DW +: DW]));
      du2_s = DETW'($signed(rec_ff[6*EW + 2*DW +: DW]));
      dv2_s = DETW'($signed(rec_ff[6*EW + 3*DW +: DW]));
      det = DETW'(du1_s * dv2_s) - DETW'(du2_s * dv1_s);
      e1_s = TMW'($signed(rec_ff[idx_ff*EW +: EW]));
      e2_s = TMW'($signed(rec_ff[(idx_ff + 2'd3)*EW +: EW]));
      dv1_t = TMW'($signed(rec_ff[6*EW + DW +: DW]));
      dv2_t = TMW'($signed(rec_ff[6*EW + 3*DW +: DW]));
      tval = TMW'(dv2_t * e1_s) - TMW'(dv1_t * e2_s);
      if (det_neg_ff) begin
         tval = -tval;
      end
      or_mag = mag_ff[0] | mag_ff[1] | mag_ff[2];
      sm = mag_ff[idx_ff][NORM_BITS-1:0];
      sq = sm * sm;
      trial = res_ff + bit_ff;
      ge = (num_ff >= dsr_ff);
      quo_next = {quo_ff[QUOT_BITS-2:0], ge};
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      rec_in = rec_ff;
      det_neg_in = det_neg_ff;
      deg_in = deg_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      sum_in = sum_ff;
      rad_in = rad_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      len_in = len_ff;
      num_in = num_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      tan_in = tan_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      out_deg_in = out_deg_ff;
      q_pop = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               rec_in = q_data;
               deg_in = 1'b0;
               state_in = BK_DET;
            end
         end
         BK_DET: begin
            det_neg_in = det[DETW-1];
            idx_in = 2'd0;
            if (det == '0) begin
               deg_in = 1'b1;
               state_in = BK_DONE;
            end else begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            neg_in[idx_ff] = tval[TMW-1];
            mag_in[idx_ff] = tval[TMW-1] ? -tval : tval;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               state_in = BK_NORM;
            end
         end
         BK_NORM: begin
            idx_in = 2'd0;
            sum_in = '0;
            if (or_mag == '0) begin
               deg_in = 1'b1;
               state_in = BK_DONE;
            end else if (or_mag[TMW-1:NORM_BITS] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else if (!or_mag[NORM_BITS-1]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               state_in = BK_SQ;
            end
         end
         BK_SQ: begin
            sum_in = sum_ff + SUMW'(sq);
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               rad_in = sum_in;
               res_in = '0;
               bit_in = SUMW'(1) << (2 * NORM_BITS);
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            if (bit_ff == '0) begin
               len_in = res_ff[LENW-1:0];
               idx_in = 2'd0;
               if (res_ff == '0) begin
                  deg_in = 1'b1;
                  state_in = BK_DONE;
               end else begin
                  state_in = BK_DIV_LOAD;
               end
            end else begin
               if (rad_ff >= trial) begin
                  rad_in = rad_ff - trial;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         BK_DIV_LOAD: begin
            num_in = (NUMW'(sm) << SCALE_SHIFT) + NUMW'(len_ff >> 1);
            dsr_in = NUMW'(len_ff) << SCALE_SHIFT;
            quo_in = '0;
            cnt_in = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (ge) begin
               num_in = num_ff - dsr_ff;
            end
            dsr_in = dsr_ff >> 1;
            quo_in = quo_next;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(SCALE_SHIFT)) begin
               if (quo_next > OUT_SCALE) begin
                  quo_in = OUT_SCALE;
               end
               tan_in[idx_ff] = neg_ff[idx_ff] ? -TANGENT_WIDTH'(quo_in)
                                               : TANGENT_WIDTH'(quo_in);
               idx_in = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd2) ? BK_DONE : BK_DIV_LOAD;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_deg_in = deg_ff;
               out_x_in = deg_ff ? '0 : tan_ff[0];
               out_y_in = deg_ff ? '0 : tan_ff[1];
               out_z_in = deg_ff ? '0 : tan_ff[2];
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      rec_ff <= rec_in;
      det_neg_ff <= det_neg_in;
      deg_ff <= deg_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      sum_ff <= sum_in;
      rad_ff <= rad_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      num_ff <= num_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      tan_ff <= tan_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
      out_deg_ff <= out_deg_in;
   end

endmodule

// File: rtl/ttg_checker.sv
// Port-level checks for the triangle tangent generator, bound to the top level.
module ttg_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_full,
   input logic                                     rsp_empty,
   input logic                                     rsp_pop,
   input logic signed [ttg_pkg::TANGENT_WIDTH-1:0] rsp_tangent_x,
   input logic signed [ttg_pkg::TANGENT_WIDTH-1:0] rsp_tangent_y,
   input logic signed [ttg_pkg::TANGENT_WIDTH-1:0] rsp_tangent_z,
   input logic                                     rsp_degenerate
);
   import ttg_pkg::*;

   localparam logic signed [TANGENT_WIDTH-1:0] T_MAX = TANGENT_WIDTH'(OUT_SCALE);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("response or full flag present after reset");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_degenerate) |->
         (rsp_tangent_x == '0 && rsp_tangent_y == '0 && rsp_tangent_z == '0))
      else $error("degenerate request with non-zero tangent");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_degenerate) |->
         (rsp_tangent_x <= T_MAX && rsp_tangent_x >= -T_MAX &&
          rsp_tangent_y <= T_MAX && rsp_tangent_y >= -T_MAX &&
          rsp_tangent_z <= T_MAX && rsp_tangent_z >= -T_MAX))
      else $error("tangent component outside unit range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_tangent_x) && $stable(rsp_tangent_y) &&
          $stable(rsp_tangent_z) && $stable(rsp_degenerate)))
      else $error("waiting response changed before it was taken");

endmodule

bind triangle_tangent_generator_core ttg_checker u_ttg_checker (
   .clock(clock),
   .reset(reset),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_tangent_x(rsp_tangent_x),
   .rsp_tangent_y(rsp_tangent_y),
   .rsp_tangent_z(rsp_tangent_z),
   .rsp_degenerate(rsp_degenerate)
);

// File: dv/triangle_tangent_generator_core_tb.sv
// Self-checking testbench for the triangle tangent generator core.
module triangle_tangent_generator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W = ttg_pkg::POSITION_WIDTH_DEFAULT;
   localparam int TEX_W = ttg_pkg::TEXCOORD_WIDTH_DEFAULT;
   localparam int TAN_W = ttg_pkg::TANGENT_WIDTH;
   localparam longint unsigned UNIT = 64'd1 << ttg_pkg::SCALE_SHIFT;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_CORNERS = 1100;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [TEX_W-1:0] tex_u;
      logic signed [TEX_W-1:0] tex_v;
   } corner_type;

   typedef struct packed {
      logic signed [TAN_W-1:0] tan_x;
      logic signed [TAN_W-1:0] tan_y;
      logic signed [TAN_W-1:0] tan_z;
      logic                    degenerate;
   } tangent_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic signed [TEX_W-1:0] req_tex_u = '0;
   logic signed [TEX_W-1:0] req_tex_v = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [TAN_W-1:0] rsp_tangent_x;
   logic signed [TAN_W-1:0] rsp_tangent_y;
   logic signed [TAN_W-1:0] rsp_tangent_z;
   logic rsp_degenerate;

   tangent_type expected_tangents[$];
   corner_type  held_corners[2];
   int       held_count = 0;
   int       error_count = 0;
   int       idle_cycles = 0;
   int       hold_left = 0;
   bit       sender_busy_mode = 1'b0;
   bit       receiver_busy_mode = 1'b0;

   triangle_tangent_generator_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_tex_u      (req_tex_u),
      .req_tex_v      (req_tex_v),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_tangent_x  (rsp_tangent_x),
      .rsp_tangent_y  (rsp_tangent_y),
      .rsp_tangent_z  (rsp_tangent_z),
      .rsp_degenerate (rsp_degenerate)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic int bit_length(input longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
         n++;
         v = v >> 1;
      end
      return n;
   endfunction

   function automatic tangent_type tangent_of(input corner_type c0, input corner_type c1,
                                              input corner_type c2);
      tangent_type r;
      longint e1[3], e2[3], t;
      longint du1, dv1, du2, dv2, det;
      longint unsigned mag[3], sm[3], sum, len, q;
      bit neg[3];
      int lmax;
      r = '{tan_x: '0, tan_y: '0, tan_z: '0, degenerate: 1'b1};
      e1[0] = longint'(c1.pos_x) - longint'(c0.pos_x);
      e1[1] = longint'(c1.pos_y) - longint'(c0.pos_y);
      e1[2] = longint'(c1.pos_z) - longint'(c0.pos_z);
      e2[0] = longint'(c2.pos_x) - longint'(c0.pos_x);
      e2[1] = longint'(c2.pos_y) - longint'(c0.pos_y);
      e2[2] = longint'(c2.pos_z) - longint'(c0.pos_z);
      du1 = longint'(c1.tex_u) - longint'(c0.tex_u);
      dv1 = longint'(c1.tex_v) - longint'(c0.tex_v);
      du2 = longint'(c2.tex_u) - longint'(c0.tex_u);
      dv2 = longint'(c2.tex_v) - longint'(c0.tex_v);
      det = du1 * dv2 - du2 * dv1;
      if (det == 0) return r;
      lmax = 0;
      for (int i = 0; i < 3; i++) begin
         t = dv2 * e1[i] - dv1 * e2[i];
         if (det < 0) t = -t;
         neg[i] = t < 0;
         mag[i] = neg[i] ? longint'(-t) : t;
         if (bit_length(mag[i]) > lmax) lmax = bit_length(mag[i]);
      end
      if (lmax == 0) return r;
      for (int i = 0; i < 3; i++) begin
         if (lmax > ttg_pkg::NORM_BITS) sm[i] = mag[i] >> (lmax - ttg_pkg::NORM_BITS);
         else sm[i] = mag[i] << (ttg_pkg::NORM_BITS - lmax);
      end
      sum = sm[0] * sm[0] + sm[1] * sm[1] + sm[2] * sm[2];
      len = int_sqrt(sum);
      if (len == 0) return r;
      for (int i = 0; i < 3; i++) begin
         q = (sm[i] * UNIT + len / 2) / len;
         if (q > UNIT) q = UNIT;
         if (neg[i]) q = -q;
         if (i == 0) r.tan_x = q[TAN_W-1:0];
         else if (i == 1) r.tan_y = q[TAN_W-1:0];
         else r.tan_z = q[TAN_W-1:0];
      end
      r.degenerate = 1'b0;
      return r;
   endfunction

   // Each accepted request is folded into the held corners here.
   always @(posedge clock) begin
      corner_type c;
      if (!reset && req_push && !req_full) begin
         c = '{pos_x: req_pos_x, pos_y: req_pos_y, pos_z: req_pos_z,
               tex_u: req_tex_u, tex_v: req_tex_v};
         if (held_count < 2) begin
            held_corners[held_count] = c;
            held_count++;
         end else begin
            expected_tangents = {expected_tangents,
                                 tangent_of(held_corners[0], held_corners[1], c)};
            held_count = 0;
         end
      end
   end

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // Response side: checks each popped tangent and decides the next pop.
   initial begin
      tangent_type want;
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (expected_tangents.size() == 0) begin
               $display("[%0t] tangent popped with none expected", $time);
               error_count++;
            end else begin
               want = expected_tangents.pop_front();
               if (rsp_tangent_x !== want.tan_x)
                  report_mismatch("tangent_x", rsp_tangent_x, want.tan_x);
               if (rsp_tangent_y !== want.tan_y)
                  report_mismatch("tangent_y", rsp_tangent_y, want.tan_y);
               if (rsp_tangent_z !== want.tan_z)
                  report_mismatch("tangent_z", rsp_tangent_z, want.tan_z);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_degenerate, want.degenerate);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (receiver_busy_mode) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_corner(input corner_type c);
      int gap;
      req_push  <= 1'b1;
      req_pos_x <= c.pos_x;
      req_pos_y <= c.pos_y;
      req_pos_z <= c.pos_z;
      req_tex_u <= c.tex_u;
      req_tex_v <= c.tex_v;
      do @(posedge clock); while (req_full);
      gap = sender_busy_mode ? pick_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic finish_sending();
      req_push <= 1'b0;
      @(posedge clock);
      wait (expected_tangents.size() == 0);
   endtask

   function automatic corner_type make_corner(input longint x, input longint y,
                                              input longint z, input int u, input int v);
      return '{pos_x: POS_W'(x), pos_y: POS_W'(y), pos_z: POS_W'(z),
               tex_u: TEX_W'(u), tex_v: TEX_W'(v)};
   endfunction

   function automatic corner_type random_corner();
      return '{pos_x: POS_W'($urandom), pos_y: POS_W'($urandom), pos_z: POS_W'($urandom),
               tex_u: TEX_W'($urandom), tex_v: TEX_W'($urandom)};
   endfunction

   task automatic test_directed();
      localparam longint PMAX = 64'sh7FFF_FFFF;
      localparam longint PMIN = -64'sh8000_0000;
      localparam int TMAX = 32767;
      localparam int TMIN = -32768;
      sender_busy_mode = 1'b0;
      // Ordinary unit triangle.
      send_corner(make_corner(0, 0, 0, 0, 0));
      send_corner(make_corner(65536, 0, 0, 16384, 0));
      send_corner(make_corner(0, 65536, 0, 0, 16384));
      // Field extremes on both position and texture coordinate.
      send_corner(make_corner(PMAX, PMAX, PMAX, TMAX, TMAX));
      send_corner(make_corner(PMIN, PMIN, PMIN, TMIN, TMIN));
      send_corner(make_corner(0, PMAX, PMIN, TMIN, TMAX));
      // Zero determinant: identical texture coordinates.
      send_corner(make_corner(10, 20, 30, 500, 500));
      send_corner(make_corner(-40, 50, 60, 500, 500));
      send_corner(make_corner(70, -80, 90, 500, 500));
      // Zero tangent: identical positions with a valid mapping.
      send_corner(make_corner(-12345, 999, 7, 0, 0));
      send_corner(make_corner(-12345, 999, 7, 100, 0));
      send_corner(make_corner(-12345, 999, 7, 0, 100));
      sender_busy_mode = 1'b1;
      // Negative determinant with tiny edges.
      send_corner(make_corner(0, 0, 0, 0, 0));
      send_corner(make_corner(0, 1, 0, 0, 1));
      send_corner(make_corner(1, 0, 0, 1, 0));
      // Largest texture deltas in opposite corners.
      send_corner(make_corner(PMIN, 0, PMAX, TMIN, TMIN));
      send_corner(make_corner(PMAX, PMIN, 0, TMAX, TMIN));
      send_corner(make_corner(0, PMAX, PMIN, TMIN, TMAX));
      // Back-to-back triangles to exercise the restart of the corner count.
      send_corner(random_corner());
      send_corner(random_corner());
      send_corner(random_corner());
      send_corner(make_corner(3, -3, 5, -1, 1));
      send_corner(make_corner(-7, 2, 0, 4, -2));
      send_corner(make_corner(1, 1, -9, 0, 6));
      finish_sending();
   endtask

   task automatic test_random();
      corner_type c[3];
      int kind;
      int sent;
      sent = 0;
      while (sent < RANDOM_CORNERS) begin
         if (sent % 90 == 0) begin
            sender_busy_mode = $urandom_range(0, 3) != 0;
            receiver_busy_mode = $urandom_range(0, 3) != 0;
         end
         kind = $urandom_range(0, 19);
         for (int i = 0; i < 3; i++) begin
            c[i] = random_corner();
            if (kind >= 14 && kind < 17) begin
               c[i].pos_x = $signed(c[i].pos_x) >>> $urandom_range(0, 31);
               c[i].pos_y = $signed(c[i].pos_y) >>> $urandom_range(0, 31);
               c[i].pos_z = $signed(c[i].pos_z) >>> $urandom_range(0, 31);
               c[i].tex_u = $signed(c[i].tex_u) >>> $urandom_range(0, 15);
               c[i].tex_v = $signed(c[i].tex_v) >>> $urandom_range(0, 15);
            end
         end
         if (kind == 17) begin
            // Collinear texture deltas give a zero determinant.
            c[1].tex_u = c[0].tex_u;
            c[2].tex_u = c[0].tex_u;
         end else if (kind == 18) begin
            c[1].pos_x = c[0].pos_x; c[1].pos_y = c[0].pos_y; c[1].pos_z = c[0].pos_z;
            c[2].pos_x = c[0].pos_x; c[2].pos_y = c[0].pos_y; c[2].pos_z = c[0].pos_z;
         end else if (kind == 19) begin
            c[1].tex_u = c[0].tex_u; c[1].tex_v = c[0].tex_v;
         end
         for (int i = 0; i < 3; i++) send_corner(c[i]);
         sent += 3;
      end
      finish_sending();
   endtask

   task automatic test_backpressure();
      sender_busy_mode = 1'b0;
      receiver_busy_mode = 1'b0;
      hold_left = 1500;
      for (int i = 0; i < 30; i++) send_corner(random_corner());
      finish_sending();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      wait (expected_tangents.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_tangents.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
